### sv/rhef_pkg.sv
// Package: payload types, codes and control structs of the hotkey event filter.
`default_nettype none
package rhef_pkg;

	localparam logic [2:0] CMD_KEY    = 3'd0;
	localparam logic [2:0] CMD_BIND   = 3'd1;
	localparam logic [2:0] CMD_UNBIND = 3'd2;
	localparam logic [2:0] CMD_SETEN  = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;
	localparam logic [2:0] CMD_DROP   = 3'd5;

	localparam logic [2:0] RS_DONE     = 3'd0;
	localparam logic [2:0] RS_FILTERED = 3'd1;
	localparam logic [2:0] RS_CONFLICT = 3'd2;
	localparam logic [2:0] RS_NOTFOUND = 3'd3;
	localparam logic [2:0] RS_BADKEY   = 3'd4;

	localparam logic [1:0] EK_PRESS   = 2'd0;
	localparam logic [1:0] EK_REPEAT  = 2'd1;
	localparam logic [1:0] EK_RELEASE = 2'd2;

	localparam int KC_W = 10;
	localparam int SC_W = 8;
	localparam int LIM_W = 13;

	typedef struct packed {
		logic [2:0]      cmd;
		logic [KC_W-1:0] keycode;
		logic            pressed;
		logic [3:0]      modifiers;
		logic [SC_W-1:0] shortcut_num;
		logic [2:0]      event_mask;
		logic            input_on;
		logic            session_on;
	} req_t;

	typedef struct packed {
		logic [2:0]      status;
		logic            activated;
		logic [SC_W-1:0] result_shortcut;
		logic [1:0]      event_kind;
	} rsp_t;

	typedef struct packed {
		logic            valid;
		logic [SC_W-1:0] sc;
		logic [2:0]      flags;
		logic            held;
		logic            supp;
	} entry_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_SWEEP,
		S_FIN
	} state_t;

	typedef struct packed {
		logic accept;
		logic sweep_start;
		logic sweep_run;
		logic wipe;
		logic exec_go;
		logic load_fin;
	} ctl_t;

	typedef struct packed {
		logic is_sweep;
		logic sweep_done;
		logic out_free;
	} dp_st_t;

endpackage
`default_nettype wire

### sv/rhef_req_if.sv
// Interface: command item channel.
`default_nettype none
interface rhef_req_if import rhef_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/rhef_rsp_if.sv
// Interface: result item channel.
`default_nettype none
interface rhef_rsp_if import rhef_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/rhef_ctrl.sv
// Controller: sequences single accesses, table sweeps and result loads.
`default_nettype none
module rhef_ctrl import rhef_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   req_valid,
	input  wire dp_st_t st,
	output ctl_t        ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (st.sweep_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = st.is_sweep ? S_SWEEP : S_EXEC;
				end
			end
			S_EXEC: begin
				if (st.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_SWEEP: begin
				if (st.sweep_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			S_INIT: begin
				ctl.sweep_run = 1'b1;
				ctl.wipe      = 1'b1;
			end
			S_IDLE: begin
				ctl.accept      = 1'b1;
				ctl.sweep_start = req_valid && st.is_sweep;
			end
			S_EXEC: begin
				ctl.exec_go = st.out_free;
			end
			S_SWEEP: begin
				ctl.sweep_run = 1'b1;
			end
			S_FIN: begin
				ctl.load_fin = st.out_free;
			end
			default: ctl = '0;
		endcase
	end

endmodule
`default_nettype wire

### sv/rhef_dp.sv
// Datapath: key table memory, dispatch flag, sweep pipeline and result register.
`default_nettype none
module rhef_dp import rhef_pkg::*; #(
	parameter int KEY_SLOTS      = 1024,
	parameter int SHORTCUT_COUNT = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire ctl_t ctl,
	input  wire logic req_valid,
	input  wire req_t req_data,
	input  wire logic rsp_ready,
	output logic      rsp_valid,
	output rsp_t      rsp_data,
	output dp_st_t    st
);

	localparam int DEPTH = (KEY_SLOTS < (1 << KC_W)) ? KEY_SLOTS : (1 << KC_W);
	localparam int AW = $clog2(DEPTH);
	localparam logic [LIM_W-1:0] KS_LIM = LIM_W'(KEY_SLOTS);
	localparam logic [LIM_W-1:0] SC_LIM = LIM_W'(SHORTCUT_COUNT);
	localparam logic [AW:0] CNT_END = (AW+1)'(DEPTH);

	entry_t mem_q [DEPTH];
	entry_t rd_q;
	req_t   item_q;
	logic   disp_q;
	logic   found_q;
	logic [AW:0]   cnt_q;
	logic [AW-1:0] addr_s1;
	logic          vld_s1;
	logic   res_vld_q;
	rsp_t   res_q;

	logic          take;
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] wa;
	logic [AW-1:0] ra;
	entry_t        wd;
	logic          req_snum_ok;
	logic          kc_ok;
	logic          snum_ok;
	logic          sweep_cmd;
	entry_t        ex_wd;
	logic          ex_we;
	rsp_t          ex_res;
	entry_t        sw_wd;
	logic          sw_hit;
	rsp_t          fin_res;
	logic          rd_more;

	assign take        = ctl.accept && req_valid;
	assign req_snum_ok = {{(LIM_W-SC_W){1'b0}}, req_data.shortcut_num} < SC_LIM;
	assign kc_ok       = {{(LIM_W-KC_W){1'b0}}, item_q.keycode} < KS_LIM;
	assign snum_ok     = {{(LIM_W-SC_W){1'b0}}, item_q.shortcut_num} < SC_LIM;
	assign rd_more     = cnt_q != CNT_END;

	always_comb begin
		sweep_cmd = 1'b0;
		case (req_data.cmd)
			CMD_UNBIND: sweep_cmd = req_snum_ok;
			CMD_CLEAR:  sweep_cmd = 1'b1;
			CMD_DROP:   sweep_cmd = 1'b1;
			CMD_SETEN:  sweep_cmd = disp_q && !(req_data.input_on && req_data.session_on);
			default:    sweep_cmd = 1'b0;
		endcase
	end
	assign st.is_sweep   = sweep_cmd;
	assign st.sweep_done = !rd_more && !vld_s1;
	assign st.out_free   = !res_vld_q || rsp_ready;

	always_comb begin
		ex_res = '0;
		ex_we  = 1'b0;
		ex_wd  = rd_q;
		case (item_q.cmd)
			CMD_KEY: begin
				if (!kc_ok) begin
					ex_res.status = RS_BADKEY;
				end else begin
					ex_we = 1'b1;
					ex_res.status = RS_FILTERED;
					if (!disp_q) begin
						ex_wd.supp = item_q.pressed;
					end else if (rd_q.supp) begin
						if (!item_q.pressed) begin
							ex_wd.supp = 1'b0;
						end
					end else if (!rd_q.valid) begin
						ex_we = 1'b0;
					end else if (item_q.modifiers != 4'd0) begin
						ex_wd.held = 1'b0;
						if (item_q.pressed) begin
							ex_wd.supp = 1'b1;
						end
					end else if (item_q.pressed) begin
						if (!rd_q.held) begin
							ex_wd.held = 1'b1;
							if (rd_q.flags[0]) begin
								ex_res.activated = 1'b1;
								ex_res.event_kind = EK_PRESS;
							end
						end else if (rd_q.flags[1]) begin
							ex_res.activated = 1'b1;
							ex_res.event_kind = EK_REPEAT;
						end
					end else if (rd_q.held) begin
						ex_wd.held = 1'b0;
						if (rd_q.flags[2]) begin
							ex_res.activated = 1'b1;
							ex_res.event_kind = EK_RELEASE;
						end
					end
					if (ex_res.activated) begin
						ex_res.status = RS_DONE;
						ex_res.result_shortcut = rd_q.sc;
					end
				end
			end
			CMD_BIND: begin
				if (item_q.keycode == '0 || !kc_ok) begin
					ex_res.status = RS_BADKEY;
				end else if (!snum_ok) begin
					ex_res.status = RS_NOTFOUND;
				end else if (rd_q.valid) begin
					ex_res.status = RS_CONFLICT;
					ex_res.result_shortcut = rd_q.sc;
				end else begin
					ex_we = 1'b1;
					ex_wd.valid = 1'b1;
					ex_wd.sc = item_q.shortcut_num;
					ex_wd.flags = item_q.event_mask;
				end
			end
			CMD_UNBIND: ex_res.status = RS_NOTFOUND;
			default:    ex_res.status = RS_DONE;
		endcase
	end

	always_comb begin
		sw_wd  = rd_q;
		sw_hit = 1'b0;
		if (ctl.wipe) begin
			sw_wd = '0;
		end else begin
			case (item_q.cmd)
				CMD_CLEAR: sw_wd = '0;
				CMD_UNBIND: begin
					if (rd_q.valid && rd_q.sc == item_q.shortcut_num) begin
						sw_wd  = '0;
						sw_hit = 1'b1;
					end
				end
				CMD_SETEN: begin
					sw_wd.supp = rd_q.supp | rd_q.held;
					sw_wd.held = 1'b0;
				end
				CMD_DROP: begin
					sw_wd.supp = 1'b0;
					sw_wd.held = 1'b0;
				end
				default: sw_wd = rd_q;
			endcase
		end
	end

	always_comb begin
		fin_res = '0;
		fin_res.status = (item_q.cmd == CMD_UNBIND && !found_q) ? RS_NOTFOUND : RS_DONE;
	end

	assign mem_re = take || (ctl.sweep_run && rd_more);
	assign ra     = ctl.sweep_run ? cnt_q[AW-1:0] : req_data.keycode[AW-1:0];
	assign mem_we = (ctl.exec_go && ex_we) || (ctl.sweep_run && vld_s1);
	assign wa     = ctl.sweep_run ? addr_s1 : item_q.keycode[AW-1:0];
	assign wd     = ctl.sweep_run ? sw_wd : ex_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wa] <= wd;
		end
		if (mem_re) begin
			rd_q <= mem_q[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= req_data;
		end
		if (ctl.sweep_run && rd_more) begin
			addr_s1 <= cnt_q[AW-1:0];
		end
		if (ctl.exec_go) begin
			res_q <= ex_res;
		end else if (ctl.load_fin) begin
			res_q <= fin_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_q    <= 1'b1;
			found_q   <= 1'b0;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (take && req_data.cmd == CMD_SETEN) begin
				disp_q <= req_data.input_on & req_data.session_on;
			end
			if (ctl.sweep_start) begin
				cnt_q   <= '0;
				vld_s1  <= 1'b0;
				found_q <= 1'b0;
			end else if (ctl.sweep_run) begin
				if (rd_more) begin
					cnt_q <= cnt_q + 1'b1;
				end
				vld_s1 <= rd_more;
				if (vld_s1 && sw_hit) begin
					found_q <= 1'b1;
				end
			end
			if (ctl.exec_go || ctl.load_fin) begin
				res_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = res_vld_q;
	assign rsp_data  = res_q;

endmodule
`default_nettype wire

### sv/raw_hotkey_event_filter_core.sv
// Top level: hotkey event filter with per-key binding table.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   cmd, keycode, pressed, modifiers, shortcut_num,
//                               event_mask, input_on, session_on
//   rsp      out  valid/ready   status, activated, result_shortcut, event_kind
//
// Key event, bind and the short commands take one memory read and one write.
// Unbind of an in-range shortcut, clear all, drop and a set enables that turns
// dispatch off sweep every table entry through its separate read and write ports.
// After reset a pass clears all min(KEY_SLOTS,1024) entries; no item is taken.
// One item is in work at a time; a result waits in the output register while
// the next item is taken, and a full register stalls only the final step.
`default_nettype none
module raw_hotkey_event_filter_core import rhef_pkg::*; #(
	parameter int KEY_SLOTS      = 1024,
	parameter int SHORTCUT_COUNT = 256
) (
	input wire logic   clk,
	input wire logic   arst_n,
	rhef_req_if.sink   req,
	rhef_rsp_if.source rsp
);

	ctl_t   ctl;
	dp_st_t st;

	rhef_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.st        (st),
		.ctl       (ctl)
	);

	rhef_dp #(
		.KEY_SLOTS      (KEY_SLOTS),
		.SHORTCUT_COUNT (SHORTCUT_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.req_valid (req.valid),
		.req_data  (req.data),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.rsp_data  (rsp.data),
		.st        (st)
	);

	assign req.ready = ctl.accept;

endmodule
`default_nettype wire
